// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the IPv4 receive header filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// File: hw/rtl/ipv4rx_pkg.sv
// ----------------------------------------------------------------------------
// ipv4rx_pkg
// Types and constants for the IPv4 receive header filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv4rx_pkg;

  // Header geometry
  localparam int HeaderBytes = 20;
  localparam int IdxW        = $clog2(HeaderBytes + 1);

  localparam logic [IdxW-1:0] IdxVersion  = IdxW'(0);
  localparam logic [IdxW-1:0] IdxFragHi   = IdxW'(6);
  localparam logic [IdxW-1:0] IdxFragLo   = IdxW'(7);
  localparam logic [IdxW-1:0] IdxTtl      = IdxW'(8);
  localparam logic [IdxW-1:0] IdxProto    = IdxW'(9);
  localparam logic [IdxW-1:0] IdxCsumHi   = IdxW'(10);
  localparam logic [IdxW-1:0] IdxCsumLo   = IdxW'(11);
  localparam logic [IdxW-1:0] IdxDestBase = IdxW'(16);
  localparam logic [IdxW-1:0] IdxLast     = IdxW'(HeaderBytes - 1);
  localparam logic [IdxW-1:0] IdxIdle     = IdxW'(HeaderBytes);

  localparam logic [7:0] VersionIhl   = 8'h45;
  localparam logic [7:0] FragHiMask   = 8'h3F;
  localparam logic [7:0] ProtoIcmp    = 8'd1;
  localparam logic [7:0] ProtoUdp     = 8'd17;
  localparam logic [3:0] MulticastTop = 4'hE;

  // Check flag bit positions
  localparam int FlagVersion = 0;
  localparam int FlagFrag    = 1;
  localparam int FlagTtl     = 2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOCAL_ADDR  = 2'd0,
    CFG_SUBNET_MASK = 2'd1,
    CFG_HANDLER     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    DROP_NONE     = 3'd0,
    DROP_VERSION  = 3'd1,
    DROP_FRAGMENT = 3'd2,
    DROP_TTL      = 3'd3,
    DROP_ADDRESS  = 3'd4,
    DROP_CHECKSUM = 3'd5
  } drop_reason_e;

  typedef enum logic [1:0] {
    ROUTE_ICMP       = 2'd0,
    ROUTE_UDP        = 2'd1,
    ROUTE_HANDLER    = 2'd2,
    ROUTE_NO_HANDLER = 2'd3
  } route_e;

  // Collected header state handed to the verdict logic
  typedef struct packed {
    logic [2:0]  flags;
    logic [31:0] dest;
    logic [16:0] sum;
    logic [15:0] stored_csum;
    logic [7:0]  protocol;
  } hdr_status_t;

  typedef struct packed {
    logic [7:0]   protocol;
    route_e       route;
    drop_reason_e reason;
    logic         accepted;
  } verdict_t;

endpackage

// File: hw/rtl/ipv4_receive_header_filter.sv
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter
// Byte-wide IPv4 header checker giving one verdict per 20-byte header.
// ----------------------------------------------------------------------------
// The block takes one header byte per cycle on the slave stream, with tuser
// marking the first byte of a packet, and after the twentieth byte sends one
// verdict transaction: pass flag, drop reason, protocol route and protocol.
// Each byte passes an input register and then a result register; the
// verdict is formed from the last byte in the input register and held in
// the result register. A new byte is taken every cycle while the master
// side takes verdicts; the result register is the only point of backpressure.
// Bytes outside a header (no start mark after a verdict or after reset) are
// dropped silently, and a start mark in mid-header abandons that header
// without a verdict. The user must write configuration through the plain
// write port only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ipv4_receive_header_filter
  import ipv4rx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // header byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] header_byte
  input  logic        s_axis_tuser,   // [0] start_of_packet
  // verdict stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] accepted, [3:1] drop_reason,
                                      // [5:4] route, [13:6] protocol, [15:14] 0
);

  // Configuration registers
  logic [31:0] local_addr_q;
  logic [31:0] subnet_mask_q;
  logic        handler_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q  <= 32'h0000_0000;
      subnet_mask_q <= 32'hFFFF_FF00;
      handler_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOCAL_ADDR:  local_addr_q  <= cfg_data_i;
        CFG_SUBNET_MASK: subnet_mask_q <= cfg_data_i;
        CFG_HANDLER:     handler_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic in_valid_q;
  logic [7:0] byte_q;
  logic sop_q;
  logic out_valid_q;
  verdict_t out_q;
  logic advance;
  logic step;
  logic in_stall;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign step          = in_valid_q && advance;
  assign in_stall      = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      byte_q <= s_axis_tdata;
      sop_q  <= s_axis_tuser;
    end
  end

  // Header state
  logic [IdxW-1:0] idx_q, idx_d, idx_cur;
  logic [16:0] sum_q, sum_d, sum_cur;
  logic [7:0]  high_q, high_d, high_cur;
  logic [15:0] csum_q, csum_d, csum_cur;
  logic [31:0] dest_q, dest_d, dest_cur;
  logic [2:0]  flags_q, flags_d, flags_cur;
  logic [7:0]  proto_q, proto_d, proto_cur;
  logic        active;
  logic        last_byte;
  logic [15:0] word;
  logic [17:0] sum_wide;
  hdr_status_t status;
  verdict_t    verdict;

  // A start mark restarts the header from cleared state
  always_comb begin
    if (sop_q) begin
      idx_cur   = '0;
      sum_cur   = '0;
      high_cur  = '0;
      csum_cur  = '0;
      dest_cur  = '0;
      flags_cur = '0;
      proto_cur = '0;
    end else begin
      idx_cur   = idx_q;
      sum_cur   = sum_q;
      high_cur  = high_q;
      csum_cur  = csum_q;
      dest_cur  = dest_q;
      flags_cur = flags_q;
      proto_cur = proto_q;
    end
  end

  assign active    = sop_q || (idx_q < IdxIdle);
  assign last_byte = step && active && (idx_cur == IdxLast);

  // Per-byte field capture and checksum fold
  always_comb begin
    idx_d   = idx_cur + IdxW'(1);
    high_d  = high_cur;
    csum_d  = csum_cur;
    dest_d  = dest_cur;
    flags_d = flags_cur;
    proto_d = proto_cur;
    sum_d   = sum_cur;
    word    = '0;
    sum_wide = '0;

    if ((idx_cur == IdxVersion) && (byte_q != VersionIhl)) begin
      flags_d[FlagVersion] = 1'b1;
    end
    if ((idx_cur == IdxFragHi) && ((byte_q & FragHiMask) != 8'h00)) begin
      flags_d[FlagFrag] = 1'b1;
    end
    if ((idx_cur == IdxFragLo) && (byte_q != 8'h00)) begin
      flags_d[FlagFrag] = 1'b1;
    end
    if ((idx_cur == IdxTtl) && (byte_q == 8'h00)) begin
      flags_d[FlagTtl] = 1'b1;
    end
    if (idx_cur == IdxProto) begin
      proto_d = byte_q;
    end
    if (idx_cur == IdxCsumHi) begin
      csum_d = {byte_q, 8'h00};
    end
    if (idx_cur == IdxCsumLo) begin
      csum_d = {csum_cur[15:8], byte_q};
    end
    if (idx_cur >= IdxDestBase) begin
      dest_d = {dest_cur[23:0], byte_q};
    end

    // Even bytes are held, odd bytes complete a 16-bit word
    if (!idx_cur[0]) begin
      high_d = byte_q;
    end else begin
      word     = (idx_cur == IdxCsumLo) ? 16'h0000 : {high_cur, byte_q};
      sum_wide = {1'b0, sum_cur} + {2'b00, word};
      sum_d    = {1'b0, sum_wide[15:0]} + {15'b0, sum_wide[17:16]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= IdxIdle;
      sum_q   <= '0;
      high_q  <= '0;
      csum_q  <= '0;
      dest_q  <= '0;
      flags_q <= '0;
      proto_q <= '0;
    end else if (step && active) begin
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      high_q  <= high_d;
      csum_q  <= csum_d;
      dest_q  <= dest_d;
      flags_q <= flags_d;
      proto_q <= proto_d;
    end
  end

  // Verdict from the state as it stands after the last byte
  always_comb begin
    status.flags       = flags_d;
    status.dest        = dest_d;
    status.sum         = sum_d;
    status.stored_csum = csum_d;
    status.protocol    = proto_d;
  end

  ipv4rx_verdict u_verdict (
    .local_addr_i  (local_addr_q),
    .subnet_mask_i (subnet_mask_q),
    .handler_i     (handler_q),
    .status_i      (status),
    .verdict_o     (verdict)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_byte) begin
      out_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  // Assertions
  `ASSERT_NEVER(a_idx_range, idx_q > IdxIdle, "byte index beyond header end")
  `ASSERT_NEVER(a_sum_folded, sum_q[16], "checksum accumulator left unfolded")
  `ASSERT_CLK(a_in_hold, in_stall |=> in_valid_q && $stable({byte_q, sop_q}), "input byte lost")
  `ASSERT_NEVER(a_drop_route, out_valid_q && !out_q.accepted && |out_q.route, "drop with route")

endmodule

// File: hw/rtl/ipv4rx_verdict.sv
// ----------------------------------------------------------------------------
// ipv4rx_verdict
// Destination, checksum and priority checks giving the header verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4rx_verdict
  import ipv4rx_pkg::*;
(
  input  logic        [31:0] local_addr_i,
  input  logic        [31:0] subnet_mask_i,
  input  logic               handler_i,
  input  hdr_status_t        status_i,
  output verdict_t           verdict_o
);

  logic dest_ok;
  logic csum_ok;

  // Own address, limited or directed broadcast, or multicast
  always_comb begin
    dest_ok = (status_i.dest == local_addr_i)
           || (status_i.dest == '1)
           || ((subnet_mask_i != '1) && ((status_i.dest | subnet_mask_i) == '1))
           || (status_i.dest[31:28] == MulticastTop);
  end

  assign csum_ok = (~status_i.sum[15:0]) == status_i.stored_csum;

  // First failing check wins, route only for passed headers
  always_comb begin
    verdict_o.protocol = status_i.protocol;
    verdict_o.route    = ROUTE_ICMP;
    if (status_i.flags[FlagVersion]) begin
      verdict_o.reason = DROP_VERSION;
    end else if (status_i.flags[FlagFrag]) begin
      verdict_o.reason = DROP_FRAGMENT;
    end else if (status_i.flags[FlagTtl]) begin
      verdict_o.reason = DROP_TTL;
    end else if (!dest_ok) begin
      verdict_o.reason = DROP_ADDRESS;
    end else if (!csum_ok) begin
      verdict_o.reason = DROP_CHECKSUM;
    end else begin
      verdict_o.reason = DROP_NONE;
    end
    verdict_o.accepted = (verdict_o.reason == DROP_NONE);
    if (verdict_o.accepted) begin
      if (status_i.protocol == ProtoIcmp) begin
        verdict_o.route = ROUTE_ICMP;
      end else if (status_i.protocol == ProtoUdp) begin
        verdict_o.route = ROUTE_UDP;
      end else if (handler_i) begin
        verdict_o.route = ROUTE_HANDLER;
      end else begin
        verdict_o.route = ROUTE_NO_HANDLER;
      end
    end
  end

endmodule
